FILE: sv/mx4inv_pkg.sv
// ----------------------------------------------------------------------------
// mx4inv_pkg
// Shared types, constants and index functions for the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package mx4inv_pkg;

    localparam int IDX_W      = 4;
    localparam int VAL_W      = 32;
    localparam int FRAC_SHIFT = 32;

    localparam logic [IDX_W-1:0] LAST_IDX     = 4'd15;
    localparam logic [2:0]       COF_LAST_PH  = 3'd4;
    localparam logic [2:0]       DET_LAST_PH  = 3'd5;
    localparam logic [2:0]       LAST_TERM    = 3'd5;
    localparam logic [1:0]       LAST_DET_COL = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COF,
        ST_DET,
        ST_DIV_GO,
        ST_DIV_RUN,
        ST_PUSH
    } state_t;

    // Column order of the six product terms of a 3x3 determinant.
    function automatic logic [1:0] perm_col(logic [2:0] t, logic [1:0] p);
        logic [5:0] cols;
        case (t)
            3'd0:    cols = {2'd2, 2'd1, 2'd0};
            3'd1:    cols = {2'd1, 2'd2, 2'd0};
            3'd2:    cols = {2'd2, 2'd0, 2'd1};
            3'd3:    cols = {2'd0, 2'd2, 2'd1};
            3'd4:    cols = {2'd1, 2'd0, 2'd2};
            3'd5:    cols = {2'd0, 2'd1, 2'd2};
            default: cols = {2'd2, 2'd1, 2'd0};
        endcase
        return cols[p*2 +: 2];
    endfunction

    // Store address of factor p of term t of cofactor k (k = col*4 + row removed).
    function automatic logic [3:0] cof_entry(logic [3:0] k, logic [2:0] t, logic [1:0] p);
        logic [1:0] r;
        logic [1:0] q;
        logic [1:0] c;
        r = (p >= k[1:0]) ? 2'(p + 2'd1) : p;
        q = perm_col(t, p);
        c = (q >= k[3:2]) ? 2'(q + 2'd1) : q;
        return {r, c};
    endfunction

    // Term sign folded with the checkerboard sign of the cofactor.
    function automatic logic cof_neg(logic [3:0] k, logic [2:0] t);
        logic tn;
        tn = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
        return tn ^ k[0] ^ k[2];
    endfunction

endpackage

FILE: sv/mx4inv_in_if.sv
// ----------------------------------------------------------------------------
// mx4inv_in_if
// Entry channel: one matrix entry and its row-major index per word.
// ----------------------------------------------------------------------------
interface mx4inv_in_if;
    logic                                   valid;
    logic                                   ready;
    logic        [mx4inv_pkg::IDX_W-1:0]    entry_index;
    logic signed [mx4inv_pkg::VAL_W-1:0]    entry_value;

    modport source (output valid, output entry_index, output entry_value, input ready);
    modport sink   (input valid, input entry_index, input entry_value, output ready);
endinterface

FILE: sv/mx4inv_out_if.sv
// ----------------------------------------------------------------------------
// mx4inv_out_if
// Result channel: one inverse entry with its flags per word.
// ----------------------------------------------------------------------------
interface mx4inv_out_if;
    logic                                   valid;
    logic                                   ready;
    logic        [mx4inv_pkg::IDX_W-1:0]    out_index;
    logic signed [mx4inv_pkg::VAL_W-1:0]    out_value;
    logic                                   singular;
    logic                                   last_out;

    modport source (output valid, output out_index, output out_value,
                    output singular, output last_out, input ready);
    modport sink   (input valid, input out_index, input out_value,
                    input singular, input last_out, output ready);
endinterface

FILE: sv/matrix_4x4_inverse.sv
// ----------------------------------------------------------------------------
// matrix_4x4_inverse
// 4x4 signed fixed-point matrix inverse by cofactor (adjugate) expansion.
// ----------------------------------------------------------------------------
// Operation: a word with index 0..14 is only stored. The word with index 15
//   is also stored and starts a run: the cofactors (96 product terms), then
//   the determinant, then each result in turn from the one-bit-per-cycle
//   divider (W = ENTRY_WIDTH quotient bits are kept).
// Runs: one run at a time; entries are refused until the run ends, and the shared multiplier and divider are reused.
// Reset: clears the sequencer and output valid; the entry store is not cleared.
module matrix_4x4_inverse #(
    parameter int ENTRY_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    mx4inv_in_if.sink    entry,
    mx4inv_out_if.source result
);
    localparam int W  = ENTRY_WIDTH;
    localparam int LW = W + 1;            // multiplier limb operand
    localparam int MW = 2 * W + 1;        // product
    localparam int CW = 3 * W + 2;        // cofactor
    localparam int DW = 4 * W + 3;        // determinant / accumulator
    localparam int NW = CW + mx4inv_pkg::FRAC_SHIFT;

    mx4inv_pkg::state_t state_reg, state_next;

    // Sequencer counters: cofactor / result index, product term, phase.
    logic [3:0] k_reg;
    logic [2:0] t_reg;
    logic [2:0] ph_reg;

    // Entry store: one write port, two registered read ports.
    logic signed [W-1:0] mem [16];
    logic signed [W-1:0] rd0_reg;
    logic signed [W-1:0] rd1_reg;
    logic [3:0]          rd_addr0;
    logic [3:0]          rd_addr1;

    // Cofactor registers, one per adjugate entry.
    logic signed [CW-1:0] cof_reg [16];
    logic [3:0]           cof_addr;
    logic signed [CW-1:0] cof_rd;
    logic [4*W-1:0]       cof_ext;
    logic [1:0]           limb_sel;
    logic [W-1:0]         limb_bits;

    // Shared multiply-accumulate datapath.
    logic signed [LW-1:0] mul_a;
    logic signed [W-1:0]  mul_b;
    logic signed [MW-1:0] mul_p;
    logic signed [MW-1:0] mreg_reg;
    logic signed [W-1:0]  phi_reg;
    logic signed [DW-1:0] acc_reg;
    logic signed [DW-1:0] addend;
    logic signed [DW-1:0] acc_sum;
    logic                 acc_clr;
    logic                 acc_add;
    logic                 acc_neg;
    logic [1:0]           acc_sh;
    logic                 phi_load;

    // Divider hookup.
    logic                 div_start;
    logic                 div_done;
    logic signed [W-1:0]  div_quot;
    logic [CW-1:0]        cof_mag;
    logic [DW-1:0]        det_mag;
    logic                 singular;

    // Result register.
    logic                          res_valid_reg;
    logic [mx4inv_pkg::IDX_W-1:0]  res_index_reg;
    logic signed [mx4inv_pkg::VAL_W-1:0] res_value_reg;
    logic                          res_sing_reg;
    logic                          res_last_reg;
    logic                          slot_free;
    logic                          push;
    logic                          in_fire;

    assign in_fire   = entry.valid && entry.ready;
    assign slot_free = !res_valid_reg || result.ready;
    assign singular  = (acc_reg == '0);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mx4inv_pkg::ST_IDLE:
            begin
                if (in_fire && entry.entry_index == mx4inv_pkg::LAST_IDX)
                    state_next = mx4inv_pkg::ST_COF;
            end
            mx4inv_pkg::ST_COF:
            begin
                if (ph_reg == mx4inv_pkg::COF_LAST_PH && t_reg == mx4inv_pkg::LAST_TERM
                    && k_reg == mx4inv_pkg::LAST_IDX)
                    state_next = mx4inv_pkg::ST_DET;
            end
            mx4inv_pkg::ST_DET:
            begin
                if (ph_reg == mx4inv_pkg::DET_LAST_PH && k_reg[1:0] == mx4inv_pkg::LAST_DET_COL)
                    state_next = mx4inv_pkg::ST_DIV_GO;
            end
            mx4inv_pkg::ST_DIV_GO:
            begin
                state_next = singular ? mx4inv_pkg::ST_PUSH : mx4inv_pkg::ST_DIV_RUN;
            end
            mx4inv_pkg::ST_DIV_RUN:
            begin
                if (div_done)
                    state_next = mx4inv_pkg::ST_PUSH;
            end
            mx4inv_pkg::ST_PUSH:
            begin
                if (slot_free)
                    state_next = (k_reg == mx4inv_pkg::LAST_IDX) ? mx4inv_pkg::ST_IDLE
                                                                 : mx4inv_pkg::ST_DIV_GO;
            end
            default: state_next = mx4inv_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath controls
    // ------------------------------------------------------------------
    // Cofactor term, phases 0..4: read two factors; multiply them; multiply the
    // low half by the third factor; add it and multiply the high half; add it.
    // Determinant column, phases 0..5: read the first-row entry; multiply the
    // four cofactor limbs by it in turn and add each at its limb offset.
    always_comb
    begin
        rd_addr0  = mx4inv_pkg::cof_entry(k_reg, t_reg, 2'd2);
        rd_addr1  = mx4inv_pkg::cof_entry(k_reg, t_reg, 2'd1);
        cof_addr  = k_reg;
        limb_sel  = 2'd0;
        mul_a     = '0;
        mul_b     = rd0_reg;
        acc_clr   = 1'b0;
        acc_add   = 1'b0;
        acc_neg   = 1'b0;
        acc_sh    = 2'd0;
        phi_load  = 1'b0;
        div_start = 1'b0;
        push      = 1'b0;
        case (state_reg)
            mx4inv_pkg::ST_COF:
            begin
                acc_neg = mx4inv_pkg::cof_neg(k_reg, t_reg);
                case (ph_reg)
                    3'd0:
                    begin
                        rd_addr0 = mx4inv_pkg::cof_entry(k_reg, t_reg, 2'd0);
                        acc_clr  = (t_reg == 3'd0);
                    end
                    3'd1:
                    begin
                        mul_a = LW'(rd0_reg);
                        mul_b = rd1_reg;
                    end
                    3'd2:
                    begin
                        mul_a    = {1'b0, mreg_reg[W-1:0]};
                        phi_load = 1'b1;
                    end
                    3'd3:
                    begin
                        mul_a   = LW'(phi_reg);
                        acc_add = 1'b1;
                    end
                    3'd4:
                    begin
                        acc_add = 1'b1;
                        acc_sh  = 2'd1;
                    end
                    default: ;
                endcase
            end
            mx4inv_pkg::ST_DET:
            begin
                rd_addr0 = {2'b00, k_reg[1:0]};
                cof_addr = {k_reg[1:0], 2'b00};
                limb_sel = 2'(ph_reg - 3'd1);
                mul_a    = (limb_sel == 2'd3) ? LW'($signed(limb_bits)) : {1'b0, limb_bits};
                // Drop the last cofactor sum before the first column
                acc_clr  = (ph_reg == 3'd0) && (k_reg[1:0] == 2'd0);
                acc_add  = (ph_reg >= 3'd2);
                acc_sh   = 2'(ph_reg - 3'd2);
            end
            mx4inv_pkg::ST_DIV_GO:
            begin
                div_start = !singular;
            end
            mx4inv_pkg::ST_PUSH:
            begin
                push = slot_free;
            end
            default: ;
        endcase
    end

    assign cof_rd    = cof_reg[cof_addr];
    assign cof_ext   = (4*W)'(cof_rd);
    assign limb_bits = cof_ext[limb_sel*W +: W];
    assign mul_p     = mul_a * mul_b;
    assign addend    = DW'(mreg_reg) <<< (acc_sh * W);
    assign acc_sum   = acc_neg ? (acc_reg - addend) : (acc_reg + addend);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mx4inv_pkg::ST_IDLE;
            k_reg     <= '0;
            t_reg     <= '0;
            ph_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                mx4inv_pkg::ST_IDLE:
                begin
                    k_reg  <= '0;
                    t_reg  <= '0;
                    ph_reg <= '0;
                end
                mx4inv_pkg::ST_COF:
                begin
                    if (ph_reg == mx4inv_pkg::COF_LAST_PH)
                    begin
                        ph_reg <= '0;
                        if (t_reg == mx4inv_pkg::LAST_TERM)
                        begin
                            t_reg <= '0;
                            k_reg <= 4'(k_reg + 1'b1);
                        end
                        else
                            t_reg <= 3'(t_reg + 1'b1);
                    end
                    else
                        ph_reg <= 3'(ph_reg + 1'b1);
                end
                mx4inv_pkg::ST_DET:
                begin
                    if (ph_reg == mx4inv_pkg::DET_LAST_PH)
                    begin
                        ph_reg <= '0;
                        k_reg  <= (k_reg[1:0] == mx4inv_pkg::LAST_DET_COL) ? 4'd0
                                                                            : 4'(k_reg + 1'b1);
                    end
                    else
                        ph_reg <= 3'(ph_reg + 1'b1);
                end
                mx4inv_pkg::ST_PUSH:
                begin
                    if (push)
                        k_reg <= 4'(k_reg + 1'b1);
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Entry store and arithmetic registers (no reset: payload only)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
            mem[entry.entry_index] <= entry.entry_value[W-1:0];
        rd0_reg <= mem[rd_addr0];
        rd1_reg <= mem[rd_addr1];
    end

    always_ff @(posedge clk)
    begin
        mreg_reg <= mul_p;
        if (phi_load)
            phi_reg <= mreg_reg[2*W-1:W];
        if (acc_clr)
            acc_reg <= '0;
        else if (acc_add)
            acc_reg <= acc_sum;
        // Last term of a cofactor: store it, sum included.
        if (state_reg == mx4inv_pkg::ST_COF && ph_reg == mx4inv_pkg::COF_LAST_PH
            && t_reg == mx4inv_pkg::LAST_TERM)
            cof_reg[k_reg] <= acc_sum[CW-1:0];
    end

    // ------------------------------------------------------------------
    // Divider: |cofactor| * 2^32 / |determinant|
    // ------------------------------------------------------------------
    assign cof_mag = cof_rd[CW-1] ? CW'(-cof_rd) : CW'(cof_rd);
    assign det_mag = acc_reg[DW-1] ? DW'(-acc_reg) : DW'(acc_reg);

    mx4inv_div #(
        .NUM_W (NW),
        .DEN_W (DW),
        .Q_W   (W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .neg     (cof_rd[CW-1] ^ acc_reg[DW-1]),
        .num_mag ({cof_mag, {mx4inv_pkg::FRAC_SHIFT{1'b0}}}),
        .den_mag (det_mag),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ------------------------------------------------------------------
    // Result register: hold the word until taken
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (push)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_index_reg <= k_reg;
            res_value_reg <= singular ? '0 : mx4inv_pkg::VAL_W'(div_quot);
            res_sing_reg  <= singular;
            res_last_reg  <= (k_reg == mx4inv_pkg::LAST_IDX);
        end
    end

    assign entry.ready      = (state_reg == mx4inv_pkg::ST_IDLE);
    assign result.valid     = res_valid_reg;
    assign result.out_index = res_index_reg;
    assign result.out_value = res_value_reg;
    assign result.singular  = res_sing_reg;
    assign result.last_out  = res_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && entry.entry_index == mx4inv_pkg::LAST_IDX |=> state_reg == mx4inv_pkg::ST_COF)
        else $error("index 15 word did not start a run");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.last_out |-> result.out_index == mx4inv_pkg::LAST_IDX)
        else $error("last word carries wrong index");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.singular |-> result.out_value == '0)
        else $error("singular word with nonzero value");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == mx4inv_pkg::ST_DIV_RUN)
        else $error("divider finished outside a division");

endmodule

FILE: sv/mx4inv_div.sv
// ----------------------------------------------------------------------------
// mx4inv_div
// Restoring divider, one quotient bit per cycle, with signed saturation.
// ----------------------------------------------------------------------------
module mx4inv_div #(
    parameter int NUM_W = 130,
    parameter int DEN_W = 131,
    parameter int Q_W   = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    neg,
    input  logic [NUM_W-1:0]        num_mag,
    input  logic [DEN_W-1:0]        den_mag,
    output logic                    done,
    output logic signed [Q_W-1:0]   quot
);
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);
    localparam logic [Q_W:0]     LIM      = (Q_W+1)'(1) << (Q_W - 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W:0]     q_reg;
    logic             big_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] diff;
    logic             ge;
    logic             over;
    logic [Q_W:0]     mag;

    assign rem_sh = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    assign ge     = !diff[DEN_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num_mag;
            den_reg <= den_mag;
            rem_reg <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DEN_W:0] : rem_sh;
            q_reg   <= {q_reg[Q_W-1:0], ge};
            big_reg <= big_reg | q_reg[Q_W];
        end
    end

    // Clamp the magnitude to the signed range, then apply the sign.
    always_comb
    begin
        if (neg_reg)
        begin
            over = big_reg || (q_reg > LIM);
            mag  = over ? LIM : q_reg;
            quot = Q_W'(~mag + 1'b1);
        end
        else
        begin
            over = big_reg || (q_reg >= LIM);
            mag  = over ? (LIM - 1'b1) : q_reg;
            quot = Q_W'(mag);
        end
    end

    assign done = done_reg;

endmodule
